/* design/ffhp_pkg.sv */
// Shared types and constants of the feed frame header parser.
package ffhp_pkg;

    localparam int MAX_DATAGRAM = 4096;
    localparam int CNT_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int HDR_BYTES    = 18;
    localparam int MIN_FRAME    = 20;
    localparam int LEN_W        = 13;

    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] LEAD_INIT = 8'd27;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_BAD_LEAD = 2'd2,
        ST_BAD_SUM  = 2'd3
    } t_status;

    // One closed frame on its way to the decoder. The header bytes are
    // zero unless the status is ok; hdr[0] is frame byte 1.
    typedef struct packed {
        t_status                        status;
        logic [LEN_W-1:0]               length;
        logic [HDR_BYTES-1:0][7:0]      hdr;
    } t_frame_evt;

endpackage

/* design/feed_frame_header_parser_top.sv */
// Top level of the feed frame header parser.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   input    | in        | i_in_valid / o_in_stall   | data_byte, last_in_datagram
//   result   | out       | o_out_valid / i_out_stall | status, length and header fields
//   config   | in        | i_cfg_valid / o_cfg_ready | lead_byte
//
// One byte beat is accepted every cycle unless o_in_stall holds it; a closed
// frame passes from the input register through the frame event register to
// the result register before it shows up on the result channel.
// Reset is synchronous and active low; it sets the lead byte to the escape
// code and clears the frame and datagram tracking.
// A stall on the result side fills the event and result registers first; the
// input side stalls only when the byte in the input register closes a frame
// and no register downstream is free.
module feed_frame_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_in_datagram,
    output logic        o_in_stall,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data,
    output logic        o_cfg_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_frame_status,
    output logic [12:0] o_frame_length,
    output logic [7:0]  o_tx_code,
    output logic [7:0]  o_msg_type,
    output logic [47:0] o_info_time_bcd,
    output logic [14:0] o_channel_number,
    output logic [33:0] o_channel_sequence,
    output logic [7:0]  o_version_number,
    output logic [14:0] o_body_size
);

    logic [7:0]           r_lead_byte;
    logic                 evt_valid;
    logic                 evt_take;
    ffhp_pkg::t_frame_evt evt;

    // The lead byte register takes a write on every cfg beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_byte <= ffhp_pkg::LEAD_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lead_byte <= i_cfg_data;
        end
    end

    // Frame cutting: byte tracking, checksum and header capture.
    ffhp_framer u_framer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_data_byte        (i_data_byte),
        .i_last_in_datagram (i_last_in_datagram),
        .o_in_stall         (o_in_stall),
        .i_lead_byte        (r_lead_byte),
        .i_evt_take         (evt_take),
        .o_evt_valid        (evt_valid),
        .o_evt              (evt)
    );

    // BCD decode of the header into the result register.
    ffhp_decode u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_evt_valid         (evt_valid),
        .i_evt               (evt),
        .o_evt_take          (evt_take),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_frame_status      (o_frame_status),
        .o_frame_length      (o_frame_length),
        .o_tx_code           (o_tx_code),
        .o_msg_type          (o_msg_type),
        .o_info_time_bcd     (o_info_time_bcd),
        .o_channel_number    (o_channel_number),
        .o_channel_sequence  (o_channel_sequence),
        .o_version_number    (o_version_number),
        .o_body_size         (o_body_size)
    );

endmodule

/* design/ffhp_framer.sv */
// Input register, frame tracking state and the closed-frame register.
module ffhp_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_in_datagram,
    output logic                 o_in_stall,
    input  logic [7:0]           i_lead_byte,
    input  logic                 i_evt_take,
    output logic                 o_evt_valid,
    output ffhp_pkg::t_frame_evt o_evt
);

    logic                                   r_a_valid;
    logic [7:0]                             r_a_byte;
    logic                                   r_a_last;
    logic                                   r_b_valid;
    ffhp_pkg::t_frame_evt                   r_b_evt;
    logic [ffhp_pkg::CNT_W-1:0]             r_pos;
    logic [ffhp_pkg::CNT_W-1:0]             r_cnt;
    logic                                   r_prev_cr;
    logic [7:0]                             r_first;
    logic [7:0]                             r_xor;
    logic [7:0]                             r_recent0;
    logic [7:0]                             r_recent1;
    logic [ffhp_pkg::HDR_BYTES-1:0][7:0]    r_store;

    logic                                   active;
    logic                                   a_close;
    logic                                   a_go;
    logic                                   b_free;
    logic [ffhp_pkg::CNT_W-1:0]             len;
    ffhp_pkg::t_status                      status;
    ffhp_pkg::t_frame_evt                   evt;

    assign active  = r_pos < ffhp_pkg::CNT_W'(ffhp_pkg::MAX_DATAGRAM);
    assign a_close = r_a_valid && active && (r_a_byte == ffhp_pkg::LF_BYTE) && r_prev_cr;
    assign b_free  = !r_b_valid || i_evt_take;
    assign a_go    = r_a_valid && (!a_close || b_free);
    assign o_in_stall  = r_a_valid && !a_go;
    assign o_evt_valid = r_b_valid;
    assign o_evt       = r_b_evt;
    assign len         = r_cnt + 1'b1;

    always_comb begin
        priority if (len < ffhp_pkg::CNT_W'(ffhp_pkg::MIN_FRAME)) begin
            status = ffhp_pkg::ST_SHORT;
        end else if (r_first != i_lead_byte) begin
            status = ffhp_pkg::ST_BAD_LEAD;
        end else if (r_xor != r_recent1) begin
            status = ffhp_pkg::ST_BAD_SUM;
        end else begin
            status = ffhp_pkg::ST_OK;
        end
        evt.status = status;
        evt.length = ffhp_pkg::LEN_W'(len);
        evt.hdr    = (status == ffhp_pkg::ST_OK) ? r_store : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_a_byte <= i_data_byte;
            r_a_last <= i_last_in_datagram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_go && a_close) begin
            r_b_valid <= 1'b1;
        end else if (i_evt_take) begin
            r_b_valid <= 1'b0;
        end
        if (a_go && a_close) begin
            r_b_evt <= evt;
        end
    end

    // Header store holds frame bytes 1 to 18; it has no reset.
    always_ff @(posedge i_clk) begin
        if (a_go && active && !a_close) begin
            for (int i = 0; i < ffhp_pkg::HDR_BYTES; i++) begin
                if (r_cnt == ffhp_pkg::CNT_W'(i + 1)) begin
                    r_store[i] <= r_a_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_cnt     <= '0;
            r_prev_cr <= 1'b0;
            r_first   <= '0;
            r_xor     <= '0;
            r_recent0 <= '0;
            r_recent1 <= '0;
        end else if (a_go) begin
            if (active) begin
                r_pos <= r_pos + 1'b1;
                if (a_close) begin
                    r_cnt     <= '0;
                    r_prev_cr <= 1'b0;
                    r_first   <= '0;
                    r_xor     <= '0;
                    r_recent0 <= '0;
                    r_recent1 <= '0;
                end else begin
                    if (r_cnt == '0) begin
                        r_first <= r_a_byte;
                    end
                    if (r_cnt >= ffhp_pkg::CNT_W'(3)) begin
                        r_xor <= r_xor ^ r_recent1;
                    end
                    r_recent1 <= r_recent0;
                    r_recent0 <= r_a_byte;
                    r_cnt     <= r_cnt + 1'b1;
                    r_prev_cr <= (r_a_byte == ffhp_pkg::CR_BYTE);
                end
            end
            if (r_a_last) begin
                r_pos     <= '0;
                r_cnt     <= '0;
                r_prev_cr <= 1'b0;
                r_first   <= '0;
                r_xor     <= '0;
                r_recent0 <= '0;
                r_recent1 <= '0;
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && r_a_last |=> r_cnt == '0 && r_pos == '0 && !r_prev_cr)
        else $error("datagram end did not clear the frame state");

    a_close_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && a_close |=> r_b_valid && r_cnt == '0)
        else $error("closed frame did not reach the event register");

    a_ok_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_evt.status == ffhp_pkg::ST_OK |->
            r_b_evt.length >= ffhp_pkg::LEN_W'(ffhp_pkg::MIN_FRAME))
        else $error("ok frame shorter than the minimum");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !i_evt_take |=> r_b_valid && $stable(r_b_evt))
        else $error("pending frame event was lost");

endmodule

/* design/ffhp_decode.sv */
// Header decode into the result register.
module ffhp_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_evt_valid,
    input  ffhp_pkg::t_frame_evt i_evt,
    output logic                 o_evt_take,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_frame_status,
    output logic [12:0]          o_frame_length,
    output logic [7:0]           o_tx_code,
    output logic [7:0]           o_msg_type,
    output logic [47:0]          o_info_time_bcd,
    output logic [14:0]          o_channel_number,
    output logic [33:0]          o_channel_sequence,
    output logic [7:0]           o_version_number,
    output logic [14:0]          o_body_size
);

    // Two BCD digits to binary: high * 10 + low.
    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    logic                                   r_valid;
    logic                                   go;
    logic [ffhp_pkg::HDR_BYTES-1:0][7:0]    pair;
    logic [14:0]                            chan;
    logic [33:0]                            seq;
    logic [14:0]                            body;

    assign go          = !r_valid || !i_out_stall;
    assign o_evt_take  = go;
    assign o_out_valid = r_valid;

    always_comb begin
        for (int i = 0; i < ffhp_pkg::HDR_BYTES; i++) begin
            pair[i] = bcd_pair(i_evt.hdr[i]);
        end
        chan = 15'(pair[8]) * 15'd100 + 15'(pair[9]);
        seq  = 34'(pair[10]) * 34'd100000000 + 34'(pair[11]) * 34'd1000000
             + 34'(pair[12]) * 34'd10000 + 34'(pair[13]) * 34'd100 + 34'(pair[14]);
        body = 15'(pair[16]) * 15'd100 + 15'(pair[17]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (go) begin
            r_valid <= i_evt_valid;
        end
        if (go && i_evt_valid) begin
            o_frame_status      <= i_evt.status;
            o_frame_length      <= i_evt.length;
            o_tx_code           <= i_evt.hdr[0];
            o_msg_type          <= i_evt.hdr[1];
            o_info_time_bcd     <= {i_evt.hdr[2], i_evt.hdr[3], i_evt.hdr[4],
                                    i_evt.hdr[5], i_evt.hdr[6], i_evt.hdr[7]};
            o_channel_number    <= chan;
            o_channel_sequence  <= seq;
            o_version_number    <= pair[15];
            o_body_size         <= body;
        end
    end

endmodule

/* tb/tb_feed_frame_header_parser_top.sv */
// Self-checking testbench for the feed frame header parser.
module tb_feed_frame_header_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded frame as it leaves the block. The member order matches the
    // order of the result ports, so the ports can be packed straight into it.
    typedef struct packed {
        ffhp_pkg::t_status status;
        logic [12:0]       length;
        logic [7:0]        tx_code;
        logic [7:0]        msg_type;
        logic [47:0]       time_bcd;
        logic [14:0]       chan_num;
        logic [33:0]       chan_seq;
        logic [7:0]        version;
        logic [14:0]       body_size;
    } t_frame_hdr;

    // Shapes of frame the stimulus generator can put into a datagram.
    typedef enum int {
        FK_OK,
        FK_BAD_LEAD,
        FK_BAD_SUM,
        FK_SHORT,
        FK_NOISE
    } t_frame_kind;

    // The scoreboard tracks the frame cutter byte by byte. Every accepted input
    // beat goes through note_byte, which queues a decoded header whenever a
    // CR LF closes a frame. Every accepted result beat is compared against the
    // oldest queued header.
    class t_frame_scoreboard;
        logic [7:0]  lead;
        bit          prev_cr;
        int unsigned byte_cnt;
        int unsigned dg_pos;
        logic [7:0]  first_b;
        logic [7:0]  run_xor;
        logic [7:0]  recent [2];
        logic [7:0]  hdr [ffhp_pkg::HDR_BYTES];
        t_frame_hdr  pending_q [$];
        int          errors;

        function new();
            lead    = ffhp_pkg::LEAD_INIT;
            prev_cr = 1'b0;
            dg_pos  = 0;
            errors  = 0;
            foreach (hdr[i]) hdr[i] = 8'h00;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_cnt  = 0;
            first_b   = 8'h00;
            run_xor   = 8'h00;
            recent[0] = 8'h00;
            recent[1] = 8'h00;
        endfunction

        // Each header byte is two BCD digits, read as high * 10 + low even when
        // a nibble is above nine; bytes fold in base one hundred, first byte first.
        function longint unsigned bcd_fold(int first, int count);
            longint unsigned acc;
            logic [7:0]      b;
            acc = 0;
            for (int i = 0; i < count; i++) begin
                b   = hdr[(first + i) % ffhp_pkg::HDR_BYTES];
                acc = acc * 64'd100 + 64'(b[7:4]) * 64'd10 + 64'(b[3:0]);
            end
            return acc;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_frame_hdr  want;
            int unsigned len;
            // Bytes past the datagram size limit are dropped, but their end
            // mark still closes the datagram.
            if (dg_pos < ffhp_pkg::MAX_DATAGRAM) begin
                dg_pos++;
                if (b == ffhp_pkg::LF_BYTE && prev_cr) begin
                    len  = byte_cnt + 1;
                    want = '0;
                    if (len < ffhp_pkg::MIN_FRAME) begin
                        want.status = ffhp_pkg::ST_SHORT;
                    end else if (first_b != lead) begin
                        want.status = ffhp_pkg::ST_BAD_LEAD;
                    end else if (run_xor != recent[1]) begin
                        want.status = ffhp_pkg::ST_BAD_SUM;
                    end else begin
                        want.status = ffhp_pkg::ST_OK;
                    end
                    want.length = len[ffhp_pkg::LEN_W-1:0];
                    if (want.status == ffhp_pkg::ST_OK) begin
                        want.tx_code   = hdr[0];
                        want.msg_type  = hdr[1];
                        want.time_bcd  = {hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]};
                        want.chan_num  = 15'(bcd_fold(8, 2));
                        want.chan_seq  = 34'(bcd_fold(10, 5));
                        want.version   = 8'(bcd_fold(15, 1));
                        want.body_size = 15'(bcd_fold(16, 2));
                    end
                    pending_q.insert(pending_q.size(), want);
                    prev_cr = 1'b0;
                    clear_frame();
                end else begin
                    if (byte_cnt == 0) begin
                        first_b = b;
                    end else if (byte_cnt <= ffhp_pkg::HDR_BYTES) begin
                        hdr[byte_cnt - 1] = b;
                    end
                    // The checksum runs two bytes behind the newest byte, so
                    // at the LF it covers everything between lead and checksum.
                    if (byte_cnt >= 3) run_xor ^= recent[1];
                    recent[1] = recent[0];
                    recent[0] = b;
                    byte_cnt++;
                    prev_cr = (b == ffhp_pkg::CR_BYTE);
                end
            end
            if (last) begin
                dg_pos  = 0;
                prev_cr = 1'b0;
                clear_frame();
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_frame(t_frame_hdr got);
            t_frame_hdr want;
            if (pending_q.size() == 0) begin
                $error("result beat with no frame waiting: status %0d, length %0d",
                       got.status, got.length);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            check_field("frame_status",     64'(want.status),    64'(got.status));
            check_field("frame_length",     64'(want.length),    64'(got.length));
            check_field("tx_code",          64'(want.tx_code),   64'(got.tx_code));
            check_field("msg_type",         64'(want.msg_type),  64'(got.msg_type));
            check_field("info_time_bcd",    64'(want.time_bcd),  64'(got.time_bcd));
            check_field("channel_number",   64'(want.chan_num),  64'(got.chan_num));
            check_field("channel_sequence", 64'(want.chan_seq),  64'(got.chan_seq));
            check_field("version_number",   64'(want.version),   64'(got.version));
            check_field("body_size",        64'(want.body_size), 64'(got.body_size));
        endfunction

        function void report_leftover();
            if (pending_q.size() > 0) begin
                $error("%0d decoded frames never came out of the block", pending_q.size());
                errors++;
            end
        endfunction
    endclass

    // Roughly 1450 byte beats in all: each phase stops at the end of the
    // datagram that crosses this count, which adds about half a datagram.
    localparam int unsigned PHASE_BEATS = 300;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic [7:0]  i_data_byte        = 8'h00;
    logic        i_last_in_datagram = 1'b0;
    logic        i_cfg_valid        = 1'b0;
    logic [7:0]  i_cfg_data         = 8'h00;
    logic        i_out_stall        = 1'b0;
    logic        o_in_stall;
    logic        o_cfg_ready;
    logic        o_out_valid;
    logic [1:0]  o_frame_status;
    logic [12:0] o_frame_length;
    logic [7:0]  o_tx_code;
    logic [7:0]  o_msg_type;
    logic [47:0] o_info_time_bcd;
    logic [14:0] o_channel_number;
    logic [33:0] o_channel_sequence;
    logic [7:0]  o_version_number;
    logic [14:0] o_body_size;

    t_frame_scoreboard sb;
    logic [7:0]        dgram [$];
    bit                burst_mode = 1'b0;

    feed_frame_header_parser_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_data_byte         (i_data_byte),
        .i_last_in_datagram  (i_last_in_datagram),
        .o_in_stall          (o_in_stall),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_data          (i_cfg_data),
        .o_cfg_ready         (o_cfg_ready),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_status      (o_frame_status),
        .o_frame_length      (o_frame_length),
        .o_tx_code           (o_tx_code),
        .o_msg_type          (o_msg_type),
        .o_info_time_bcd     (o_info_time_bcd),
        .o_channel_number    (o_channel_number),
        .o_channel_sequence  (o_channel_sequence),
        .o_version_number    (o_version_number),
        .o_body_size         (o_body_size)
    );

    // 100 MHz clock. Stimulus changes on the falling edge and everything is
    // sampled on the rising edge, so there are no races inside a time step.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Header bytes are mostly well-formed BCD, sometimes the largest valid
    // pair, and sometimes arbitrary so that nibbles above nine are exercised.
    function automatic logic [7:0] header_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        if (r == 6) return 8'h99;
        return 8'($urandom);
    endfunction

    // Adds one byte to the end of the datagram being built.
    function automatic void put_byte(logic [7:0] b);
        dgram.insert(dgram.size(), b);
    endfunction

    // Appends one CR LF terminated frame of the given length to the datagram.
    // Body bytes never form an early CR LF, and the byte in front of the
    // checksum is never a CR, so the frame closes exactly where intended.
    function automatic void append_frame(t_frame_kind kind, int flen);
        logic [7:0] b;
        logic [7:0] sum;
        logic [7:0] prev;
        b = sb.lead;
        if (kind == FK_BAD_LEAD) b = b ^ 8'($urandom_range(1, 255));
        put_byte(b);
        sum = 8'h00;
        for (int i = 1; i <= flen - 4; i++) begin
            prev = dgram[dgram.size() - 1];
            b    = (i <= ffhp_pkg::HDR_BYTES) ? header_byte() : 8'($urandom);
            if (prev == ffhp_pkg::CR_BYTE && b == ffhp_pkg::LF_BYTE) b = 8'h0B;
            if (i == flen - 4 && b == ffhp_pkg::CR_BYTE) b = 8'h0C;
            sum ^= b;
            put_byte(b);
        end
        if (kind == FK_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
        put_byte(sum);
        put_byte(ffhp_pkg::CR_BYTE);
        put_byte(ffhp_pkg::LF_BYTE);
    endfunction

    // Line noise, heavy in CR and LF so that stray and tiny frames show up.
    function automatic void append_noise(int count);
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 3);
            if (r == 0) put_byte(ffhp_pkg::CR_BYTE);
            else if (r == 1) put_byte(ffhp_pkg::LF_BYTE);
            else put_byte(8'($urandom));
        end
    endfunction

    function automatic int frame_len(t_frame_kind kind);
        int unsigned r;
        if (kind == FK_SHORT) return $urandom_range(4, ffhp_pkg::MIN_FRAME - 1);
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(ffhp_pkg::MIN_FRAME, 40);
        if (r < 97) return $urandom_range(41, 120);
        return $urandom_range(121, 400);
    endfunction

    // A datagram carries one to four frames, mostly good ones, and now and then
    // ends in a partial frame that the block must throw away.
    function automatic void build_datagram();
        int unsigned r;
        int unsigned n_frames;
        t_frame_kind kind;
        n_frames = $urandom_range(1, 4);
        for (int f = 0; f < n_frames; f++) begin
            r = $urandom_range(0, 99);
            if (r < 60) kind = FK_OK;
            else if (r < 70) kind = FK_BAD_LEAD;
            else if (r < 80) kind = FK_BAD_SUM;
            else if (r < 88) kind = FK_SHORT;
            else kind = FK_NOISE;
            if (kind == FK_NOISE) append_noise($urandom_range(1, 30));
            else append_frame(kind, frame_len(kind));
        end
        if ($urandom_range(0, 9) < 3) append_noise($urandom_range(1, 8));
    endfunction

    // Drives one byte beat after an optional idle gap and holds it until the
    // block takes it. The scoreboard sees the byte at the accepting edge.
    task automatic send_beat(logic [7:0] b, logic last);
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_data_byte <= 8'($urandom);
        end
        @(negedge i_clk);
        i_in_valid         <= 1'b1;
        i_data_byte        <= b;
        i_last_in_datagram <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, last);
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++) send_beat(dgram[i], i == dgram.size() - 1);
        dgram.delete();
    endtask

    // Brings the block to rest: no input, every expected frame delivered, and
    // then an idle wait for bytes still inside its pipeline that close nothing.
    task automatic settle();
        int unsigned waited;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_q.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_lead(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.lead = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hand-picked corner cases, run with the lead byte at its reset value.
    task automatic run_directed();
        // A bare CR LF is a two-byte frame, and one more byte makes three.
        send_beat(ffhp_pkg::CR_BYTE, 1'b0);
        send_beat(ffhp_pkg::LF_BYTE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(ffhp_pkg::CR_BYTE, 1'b0);
        send_beat(ffhp_pkg::LF_BYTE, 1'b0);
        // A partial frame ends the datagram on a CR; the LF that opens the
        // next datagram must not pair with it and starts a new frame instead.
        send_beat(8'hFF, 1'b0);
        send_beat(ffhp_pkg::CR_BYTE, 1'b1);
        send_beat(ffhp_pkg::LF_BYTE, 1'b0);
        // CR CR LF still closes the frame, on the LF after the second CR.
        send_beat(ffhp_pkg::CR_BYTE, 1'b0);
        send_beat(ffhp_pkg::CR_BYTE, 1'b0);
        send_beat(ffhp_pkg::LF_BYTE, 1'b0);
        // An LF without a CR in front closes nothing, and the end mark drops
        // the partial frame; then a datagram that is a single LF.
        send_beat(8'h41, 1'b0);
        send_beat(ffhp_pkg::LF_BYTE, 1'b1);
        send_beat(ffhp_pkg::LF_BYTE, 1'b1);
    endtask

    task automatic run_phase(int unsigned beats_wanted);
        int unsigned sent;
        sent = 0;
        while (sent < beats_wanted) begin
            build_datagram();
            sent += dgram.size();
            // About one datagram in five goes out back to back with no gaps.
            burst_mode = ($urandom_range(0, 4) == 0);
            send_datagram();
        end
        burst_mode = 1'b0;
    endtask

    // Result side. The stall alternates between free-running stretches, some
    // of them long, and stall bursts drawn from the input gap mix but never empty.
    initial begin : out_stall_gen
        int unsigned run_len;
        forever begin
            run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 6);
            repeat (run_len) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat (pick_gap() + 1) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    // A result beat is taken at every rising edge with valid high and no stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_frame(t_frame_hdr'({o_frame_status, o_frame_length,
                                         o_tx_code, o_msg_type,
                                         o_info_time_bcd, o_channel_number,
                                         o_channel_sequence, o_version_number,
                                         o_body_size}));
        end
    end

    // Main sequence: reset, corner cases, then one random phase per lead byte
    // setting. The lead byte is only changed while the block is at rest.
    initial begin : main_seq
        logic [7:0] lead_plan [4];
        sb = new();
        lead_plan = '{8'hFF, 8'h00, 8'($urandom), ffhp_pkg::LEAD_INIT};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        foreach (lead_plan[p]) begin
            settle();
            write_lead(lead_plan[p]);
            run_phase(PHASE_BEATS);
        end

        settle();
        sb.report_leftover();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin : watchdog
        #15ms;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
design/ffhp_pkg.sv
design/ffhp_framer.sv
design/ffhp_decode.sv
design/feed_frame_header_parser_top.sv
tb/tb_feed_frame_header_parser_top.sv
